### src/sm3_pkg.sv
package sm3_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned CountWidth = 61;

  localparam logic [31:0] IvWords [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };
  localparam logic [31:0] TjLow  = 32'h79CC4519;
  localparam logic [31:0] TjHigh = 32'h7A879D8A;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenOffset = 6'd56;

  // Controller to datapath commands
  typedef struct packed {
    logic       buf_we;     // write buf_data at buf_addr
    logic [5:0] buf_addr;
    logic [7:0] buf_data;
    logic       load;       // load word window and a..h from buffer / cv
    logic       round;      // one round and one expansion step
    logic       fold;       // cv ^= a..h
    logic       reset_cv;   // cv back to IV
    logic       shift_out;  // rotate cv for digest readout
  } sm3_cmd_t;

  typedef struct packed {
    logic [5:0] load_idx;   // word being loaded into window (0..15)
  } sm3_aux_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

### src/sm3_datapath.sv
module sm3_datapath
  import sm3_pkg::*;
(
  input  logic        clk,
  input  sm3_cmd_t    cmd,
  input  logic [3:0]  load_word,
  input  logic [5:0]  round_idx,
  output logic [31:0] cv_head
);

  // block held as 16 big-endian words, bytes written into their lane
  logic [31:0] block_buf [BlockBytes/4];
  logic [31:0] cv [8];
  logic [31:0] w  [16];
  logic [31:0] a, b, c, d, e, f, g, h;

  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, wnew;
  logic        hi;

  // Round logic
  always_comb begin
    hi   = (round_idx >= 6'd16);
    tj   = hi ? TjHigh : TjLow;
    a12  = rotl(a, 5'd12);
    ss1  = rotl(a12 + e + rotl(tj, round_idx[4:0]), 5'd7);
    ss2  = ss1 ^ a12;
    ff   = hi ? ((a & b) | (a & c) | (b & c)) : (a ^ b ^ c);
    gg   = hi ? ((e & f) | (~e & g)) : (e ^ f ^ g);
    tt1  = ff + d + ss2 + (w[0] ^ w[4]);
    tt2  = gg + h + ss1 + w[0];
    wnew = p1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
  end

  // Block buffer, first byte of a word in its top lane
  always_ff @(posedge clk) begin
    if (cmd.buf_we) begin
      block_buf[cmd.buf_addr[5:2]][{~cmd.buf_addr[1:0], 3'b000} +: 8] <= cmd.buf_data;
    end
  end

  // Word window, working registers, chaining value
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w[15] <= block_buf[load_word];
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      if (load_word == 4'd15) begin
        a <= cv[0]; b <= cv[1]; c <= cv[2]; d <= cv[3];
        e <= cv[4]; f <= cv[5]; g <= cv[6]; h <= cv[7];
      end
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= wnew;
      d <= c; c <= rotl(b, 5'd9); b <= a; a <= tt1;
      h <= g; g <= rotl(f, 5'd19); f <= e; e <= p0(tt2);
    end
    if (cmd.fold) begin
      cv[0] <= cv[0] ^ a; cv[1] <= cv[1] ^ b; cv[2] <= cv[2] ^ c; cv[3] <= cv[3] ^ d;
      cv[4] <= cv[4] ^ e; cv[5] <= cv[5] ^ f; cv[6] <= cv[6] ^ g; cv[7] <= cv[7] ^ h;
    end else if (cmd.reset_cv) begin
      for (int i = 0; i < 8; i++) cv[i] <= IvWords[i];
    end else if (cmd.shift_out) begin
      for (int i = 0; i < 7; i++) cv[i] <= cv[i + 1];
      cv[7] <= cv[0];
    end
  end

  assign cv_head = cv[0];

endmodule

### src/sm3_control.sv
module sm3_control
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  word_index,
  output logic        last_word,
  output sm3_cmd_t    cmd,
  output logic [3:0]  load_word,
  output logic [5:0]  round_idx
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_ROUND = 7'b0001000,
    S_FOLD  = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_CLEAR = 7'b1000000
  } state_t;

  state_t                state;
  logic [CountWidth-1:0] byte_count;
  logic [5:0]            cnt;       // pad position / load word / round / digest word
  logic                  final_blk; // current block carries the length
  logic                  padding;   // message end in progress
  logic                  marked;    // pad marker already written
  logic [63:0]           bits;
  logic                  take;
  logic [5:0]            pad_pos;   // marker offset after this beat's byte
  logic                  blk_full;  // this beat's byte fills the block

  assign take      = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign word_index = cnt[2:0];
  assign last_word  = (cnt[2:0] == 3'd7);
  assign load_word  = cnt[3:0];
  assign round_idx  = cnt;
  assign bits       = {byte_count, 3'd0};
  assign pad_pos    = has_byte ? byte_count[5:0] + 6'd1 : byte_count[5:0];
  assign blk_full   = has_byte && (byte_count[5:0] == 6'd63);

  // Commands
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.buf_we   = take && has_byte;
        cmd.buf_addr = byte_count[5:0];
        cmd.buf_data = data_byte;
      end
      S_PAD: begin
        cmd.buf_we   = 1'b1;
        cmd.buf_addr = cnt;
        if (!marked && cnt == byte_count[5:0])
          cmd.buf_data = PadByte;
        else if (final_blk && cnt >= LenOffset)
          cmd.buf_data = bits[{~cnt[2:0], 3'b000} +: 8];
        else
          cmd.buf_data = 8'h00;
      end
      S_LOAD:  cmd.load = 1'b1;
      S_ROUND: cmd.round = 1'b1;
      S_FOLD:  cmd.fold = 1'b1;
      S_OUT:   cmd.shift_out = out_ready;
      S_CLEAR: cmd.reset_cv = 1'b1;
      default: cmd = '0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; byte_count <= '0; cnt <= '0;
      final_blk <= 1'b0; padding <= 1'b0; marked <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (take) begin
          if (has_byte) byte_count <= byte_count + 1'b1;
          if (blk_full) begin
            // full block goes first; an end beat pads a fresh block after it
            state <= S_LOAD; cnt <= '0; final_blk <= 1'b0;
            padding <= end_of_message; marked <= 1'b0;
          end else if (end_of_message) begin
            state <= S_PAD; cnt <= pad_pos; padding <= 1'b1; marked <= 1'b0;
            final_blk <= (pad_pos < LenOffset);
          end
        end
        S_PAD: begin
          // marker goes in once, at the offset after the last byte
          if (!marked && cnt == byte_count[5:0]) marked <= 1'b1;
          if (cnt == 6'd63) begin
            state <= S_LOAD; cnt <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_LOAD: begin
          if (cnt == 6'd15) begin
            state <= S_ROUND; cnt <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_ROUND: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          cnt <= '0;
          if (final_blk) begin
            state <= S_OUT;
          end else if (padding) begin
            state <= S_PAD;
            final_blk <= marked || (byte_count[5:0] < LenOffset);
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: if (out_ready) begin
          cnt <= cnt + 6'd1;
          if (cnt[2:0] == 3'd7) begin
            state <= S_CLEAR; byte_count <= '0; padding <= 1'b0; marked <= 1'b0;
          end
        end
        S_CLEAR: state <= S_IDLE;
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

### src/sm3_hash_engine.sv
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | data_byte, has_byte, end_of_message
// out     | out_valid / out_ready | digest_word, word_index, last_word
//
// A byte item that does not fill the block is absorbed in S_IDLE, which stays ready.
// A full block: 16 word loads, 64 rounds (one round per cycle) and a fold.
// End of message: padding sweep from the marker offset (offset 0 in a second
// padded block) to the block end, one or two padded blocks, each then
// compressed; then eight digest beats, stalled by out_ready; S_CLEAR restores IV.
// Reset is synchronous; after reset S_CLEAR loads the IV, then the engine idles.
module sm3_hash_engine
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sm3_cmd_t   cmd;
  logic [3:0] load_word;
  logic [5:0] round_idx;

  sm3_control u_ctrl (
    .clk, .rst, .data_byte, .has_byte, .end_of_message, .in_valid, .in_ready,
    .out_valid, .out_ready, .word_index, .last_word, .cmd, .load_word, .round_idx
  );

  sm3_datapath u_dp (
    .clk, .cmd, .load_word, .round_idx, .cv_head(digest_word)
  );

endmodule
